// ===== rtl/lri_pkg.sv =====
// Shared types and constants of the linear interpolation resampler.
`default_nettype none

package lri_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_RESULTS  = 64;

  localparam int CH_BITS      = 3;   // channel index
  localparam int CH_CFG_BITS  = 4;   // channels register
  localparam int STEP_BITS    = 21;  // step register, Q5.16
  localparam int POS_BITS     = 22;  // source position stays below ONE_POS + max step
  localparam int CNT_BITS     = 7;   // results of one item, plus one frame of headroom
  localparam int FS_BITS      = 2;   // frames seen, saturating at two

  localparam int QUEUE_DEPTH  = 2;   // power of two
  localparam int QPTR_BITS    = 1;

  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 24;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - SAMPLE_BITS - CH_BITS;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [POS_BITS-1:0]  ONE_POS  = POS_BITS'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0] MIN_STEP = STEP_BITS'(ONE_POS >> 3);
  localparam logic [CH_CFG_BITS-1:0] CH_MIN = CH_CFG_BITS'(1);
  localparam logic [CH_CFG_BITS-1:0] CH_MAX = CH_CFG_BITS'(MAX_CHANNELS);

  localparam logic REG_CHANNELS = 1'b0;
  localparam logic REG_STEP     = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;

  typedef enum logic [1:0] {
    END_NONE,
    END_ZERO,
    END_REPEAT
  } end_mode_e;

  typedef struct packed {
    logic [CH_CFG_BITS-1:0] ch_eff;
    logic [STEP_BITS-1:0]   step_eff;
  } lri_cfg_t;

  typedef struct packed {
    logic      frame_done;
    logic      interp;
    logic      block_end;
    end_mode_e end_mode;
    frame_t    frame;
  } lri_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lri_front.sv =====
// Input side: assembles frames, tracks frame count, issues commands to the back end.
`default_nettype none

module lri_front import lri_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire lri_cfg_t cfg_i,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire sample_t  sample_i,
  input  wire logic     block_end_i,
  input  wire logic     full_i,
  output logic          push_o,
  output lri_cmd_t      cmd_o
);

  logic [CH_BITS-1:0] ci_q, ci_d, ci_inc;
  logic [FS_BITS-1:0] fs_q, fs_d, fs_mid;
  frame_t             cur_q, frame_d;
  logic               accept, done;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;

  always_comb begin
    ci_inc          = ci_q + 1'b1;
    frame_d         = cur_q;
    frame_d[ci_q]   = sample_i;
    done            = ({1'b0, ci_inc} >= cfg_i.ch_eff) || (ci_inc == '0);
    fs_mid          = fs_q;
    if (done && fs_q != 2'd2) begin
      fs_mid = fs_q + 1'b1;
    end
    ci_d = (done || block_end_i) ? '0 : ci_inc;
    fs_d = block_end_i ? '0 : fs_mid;

    cmd_o.frame_done = done;
    cmd_o.interp     = done && (fs_q != '0);
    cmd_o.block_end  = block_end_i;
    cmd_o.frame      = frame_d;
    if (!block_end_i || fs_mid == '0) begin
      cmd_o.end_mode = END_NONE;
    end else if (fs_mid == 2'd1) begin
      cmd_o.end_mode = END_ZERO;
    end else begin
      cmd_o.end_mode = END_REPEAT;
    end
  end

  assign push_o = accept && (done || block_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q <= '0;
      fs_q <= '0;
    end else if (accept) begin
      ci_q <= ci_d;
      fs_q <= fs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= frame_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lri_cmd_queue.sv =====
// Short command queue between the front and back ends.
`default_nettype none

module lri_cmd_queue import lri_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire lri_cmd_t cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output lri_cmd_t      head_o
);

  lri_cmd_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_q, rd_q;
  logic [QPTR_BITS:0]     cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lri_back.sv =====
// Output side: walks output positions, interpolates per channel, drives results.
`default_nettype none

module lri_back import lri_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire lri_cfg_t cfg_i,
  input  wire logic     empty_i,
  input  wire lri_cmd_t head_i,
  output logic          pop_o,
  output logic          valid_o,
  input  wire logic     ready_i,
  output sample_t       sample_o,
  output logic [CH_BITS-1:0] channel_o,
  output logic          last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_END,
    ST_DONE
  } state_e;

  state_e               state_q;
  frame_t               wcur_q, prev_q;
  logic                 interp_q, block_end_q;
  end_mode_e            end_mode_q;
  logic [POS_BITS-1:0]  src_q;
  logic [CNT_BITS-1:0]  n_q, n_sum;
  logic [CH_BITS-1:0]   c_q, ch_last;

  sample_t              h_sample_q, o_sample_q;
  logic [CH_BITS-1:0]   h_ch_q, o_ch_q;
  logic                 hv_q, ov_q, o_last_q;

  logic                 o_free, gen_ok, span_active, fits, produce, skip, advance, flush, move;
  logic                 frame_end, below_one;
  sample_t              p, cv, value;
  logic signed [SAMPLE_BITS:0]     diff, frac;
  logic signed [2*SAMPLE_BITS+1:0] prod, rnd;
  logic signed [SAMPLE_BITS+1:0]   sh, sum;

  assign o_free    = !ov_q || ready_i;
  assign gen_ok    = !hv_q || o_free;
  assign below_one = src_q < ONE_POS;
  assign n_sum     = n_q + CNT_BITS'(cfg_i.ch_eff);
  assign fits      = n_sum <= CNT_BITS'(MAX_RESULTS);
  assign ch_last   = CH_BITS'(cfg_i.ch_eff - 1'b1);
  assign frame_end = (c_q == ch_last);

  always_comb begin
    span_active = 1'b0;
    case (state_q)
      ST_FRAME: span_active = interp_q && below_one;
      ST_END:   span_active = (end_mode_q != END_NONE) && below_one;
      default:  span_active = 1'b0;
    endcase
  end

  assign produce = span_active && fits && gen_ok;
  assign skip    = span_active && !fits;
  assign advance = skip || (produce && frame_end);
  assign flush   = (state_q == ST_DONE) && gen_ok;
  assign move    = hv_q && o_free && (produce || flush);
  assign pop_o   = (state_q == ST_IDLE) && !empty_i;

  // prev + ((cur - prev) * frac + half) >>> FRAC_BITS
  always_comb begin
    p    = sample_t'(prev_q[c_q]);
    cv   = sample_t'(wcur_q[c_q]);
    diff = {cv[SAMPLE_BITS-1], cv} - {p[SAMPLE_BITS-1], p};
    frac = {1'b0, src_q[FRAC_BITS-1:0]};
    prod = diff * frac;
    rnd  = prod + (2*SAMPLE_BITS+2)'(1 << (FRAC_BITS - 1));
    sh   = rnd[FRAC_BITS +: SAMPLE_BITS+2];
    sum  = {{2{p[SAMPLE_BITS-1]}}, p} + sh;
    if (state_q == ST_FRAME) begin
      value = sum[SAMPLE_BITS-1:0];
    end else if (end_mode_q == END_REPEAT) begin
      value = p;
    end else begin
      value = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      interp_q    <= 1'b0;
      block_end_q <= 1'b0;
      end_mode_q  <= END_NONE;
      src_q       <= '0;
      n_q         <= '0;
      c_q         <= '0;
      hv_q        <= 1'b0;
      ov_q        <= 1'b0;
      o_last_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            interp_q    <= head_i.interp;
            block_end_q <= head_i.block_end;
            end_mode_q  <= head_i.end_mode;
            n_q         <= '0;
            c_q         <= '0;
            state_q     <= head_i.frame_done ? ST_FRAME : ST_END;
          end
        end
        ST_FRAME: begin
          if (!span_active) begin
            if (interp_q) begin
              src_q <= src_q - ONE_POS;
            end
            state_q <= ST_END;
          end
        end
        ST_END: begin
          if (!span_active) begin
            if (block_end_q) begin
              src_q <= '0;
            end
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (gen_ok) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (advance) begin
        src_q <= src_q + POS_BITS'(cfg_i.step_eff);
      end
      if (produce) begin
        if (frame_end) begin
          c_q <= '0;
          n_q <= n_sum;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end

      if (produce) begin
        hv_q <= 1'b1;
      end else if (flush) begin
        hv_q <= 1'b0;
      end
      if (move) begin
        ov_q     <= 1'b1;
        o_last_q <= flush;
      end else if (ov_q && ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      wcur_q <= head_i.frame;
    end
    if (state_q == ST_FRAME && !span_active) begin
      prev_q <= wcur_q;
    end
    if (produce) begin
      h_sample_q <= value;
      h_ch_q     <= c_q;
    end
    if (move) begin
      o_sample_q <= h_sample_q;
      o_ch_q     <= h_ch_q;
    end
  end

  assign valid_o   = ov_q;
  assign sample_o  = o_sample_q;
  assign channel_o = o_ch_q;
  assign last_o    = o_last_q;

`ifndef SYNTHESIS
  a_idle_nothing_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !hv_q)
    else $error("held result left behind when back end went idle");

  a_result_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |-> (n_q + CNT_BITS'(cfg_i.ch_eff)) <= CNT_BITS'(MAX_RESULTS))
    else $error("result emitted beyond per-item limit");

  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> {1'b0, c_q} < cfg_i.ch_eff)
    else $error("channel counter out of range");

  a_block_end_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && block_end_q) |-> src_q == '0)
    else $error("source position not cleared at block end");

  a_last_only_on_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && !flush) |=> !o_last_q)
    else $error("last flag set on a non-final result");
`endif

endmodule

`default_nettype wire

// ===== rtl/linear_interp_resampler_core.sv =====
// Top level of the linear interpolation resampler: config registers, front, queue, back.
//
//  channel      dir  tdata / payload                       tuser  tlast
//  s_axis       in   [15:0] sample                          -      block_end
//  m_axis       out  [15:0] out_sample, [18:16] channel     -      run_last
//  apb          in   0x0 channels[3:0], 0x4 step[20:0]      -      -
//
// The front end takes one input transfer per cycle while the 2-entry command queue has room.
// The back end emits one result per cycle while m_axis_tready is high; an item that completes
// a frame or ends a block is sequenced through ST_IDLE, ST_FRAME (frame items only), ST_END and ST_DONE.
// Reset is asynchronous, active low; no clearing pass is needed.
// Output stalls back up into the queue and then into s_axis_tready.
`default_nettype none

module linear_interp_resampler_core import lri_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,   // [15:0] sample
  input  wire logic                      s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]       m_axis_tdata,   // [15:0] out_sample, [18:16] channel
  output logic                           m_axis_tlast,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [APB_DATA_BITS-1:0]  pwdata,
  output logic [APB_DATA_BITS-1:0]       prdata,
  output logic                           pready
);

  logic [CH_CFG_BITS-1:0] channels_q;
  logic [STEP_BITS-1:0]   step_q;
  lri_cfg_t               cfg;
  logic                   wr_en;

  logic                   push, full, pop, empty;
  lri_cmd_t               cmd, head;
  sample_t                out_sample;
  logic [CH_BITS-1:0]     out_ch;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= CH_CFG_BITS'(2);
      step_q     <= STEP_BITS'(65536);
    end else if (wr_en) begin
      if (paddr[2] == REG_STEP) begin
        step_q <= pwdata[STEP_BITS-1:0];
      end else begin
        channels_q <= pwdata[CH_CFG_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CHANNELS) begin
      prdata = APB_DATA_BITS'(channels_q);
    end else begin
      prdata = APB_DATA_BITS'(step_q);
    end
    if (channels_q == '0) begin
      cfg.ch_eff = CH_MIN;
    end else if (channels_q > CH_MAX) begin
      cfg.ch_eff = CH_MAX;
    end else begin
      cfg.ch_eff = channels_q;
    end
    cfg.step_eff = (step_q < MIN_STEP) ? MIN_STEP : step_q;
  end

  lri_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .sample_i    (sample_t'(s_axis_tdata[SAMPLE_BITS-1:0])),
    .block_end_i (s_axis_tlast),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  lri_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  lri_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .empty_i   (empty),
    .head_i    (head),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .sample_o  (out_sample),
    .channel_o (out_ch),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, out_ch, out_sample};

endmodule

`default_nettype wire
